/* hdl/ycc555_pkg.sv */
package ycc555_pkg;

    // Q16 color coefficients, truncated toward zero
    localparam int COEF_W = 18;
    localparam logic signed [COEF_W-1:0] K_R  = 18'sd91881;
    localparam logic signed [COEF_W-1:0] K_GB = -18'sd22550;
    localparam logic signed [COEF_W-1:0] K_GR = -18'sd46786;
    localparam logic signed [COEF_W-1:0] K_B  = 18'sd116116;

    // Q16 product of an 18-bit coefficient and centered 8-bit chroma
    localparam int PROD_W = 26;
    // offset after the shift by 16, widened for the green sum
    localparam int OFS_W  = 11;
    // per-channel working sum
    localparam int SUM_W  = 12;
    localparam int LANES  = 4;
    localparam int DITH_W = 3;

    localparam logic signed [SUM_W-1:0] LUMA_FLOOR = 12'sd16;
    localparam logic signed [SUM_W-1:0] CH_MAX     = 12'sd255;

    typedef enum logic [1:0] {
        DITHER_OFF  = 2'd0,
        DITHER_EVEN = 2'd1,
        DITHER_ODD  = 2'd2
    } t_dither_mode;

    // dither per mode, lanes ordered upper left, upper right, lower left, lower right;
    // the unused mode code adds nothing
    localparam logic [DITH_W-1:0] DITHER_TBL [4][LANES] = '{
        '{3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd2, 3'd6, 3'd0, 3'd4},
        '{3'd4, 3'd0, 3'd6, 3'd2},
        '{3'd0, 3'd0, 3'd0, 3'd0}
    };

    typedef struct packed {
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic [7:0] luma_upper_left;
        logic [7:0] luma_upper_right;
        logic [7:0] luma_lower_left;
        logic [7:0] luma_lower_right;
    } t_ycc_blk;

    typedef struct packed {
        logic [15:0] pixel_upper_left;
        logic [15:0] pixel_upper_right;
        logic [15:0] pixel_lower_left;
        logic [15:0] pixel_lower_right;
    } t_rgb_blk;

    typedef struct packed {
        logic signed [PROD_W-1:0] red;
        logic signed [PROD_W-1:0] green_cb;
        logic signed [PROD_W-1:0] green_cr;
        logic signed [PROD_W-1:0] blue;
    } t_products;

    typedef struct packed {
        logic signed [OFS_W-1:0] red;
        logic signed [OFS_W-1:0] green;
        logic signed [OFS_W-1:0] blue;
    } t_offsets;

    function automatic logic [DITH_W-1:0] dither_value(input logic [1:0] mode,
                                                      input logic [1:0] lane);
        return DITHER_TBL[mode][lane];
    endfunction

endpackage

/* hdl/ycc555_if.sv */
interface ycc555_in_if;
    import ycc555_pkg::*;

    logic     valid;
    logic     ready;
    t_ycc_blk data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ycc555_out_if;
    import ycc555_pkg::*;

    logic     valid;
    logic     ready;
    t_rgb_blk data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/ycc555_chroma_mul.sv */
module ycc555_chroma_mul (
    input  logic [7:0]            i_chroma_blue,
    input  logic [7:0]            i_chroma_red,
    output ycc555_pkg::t_products o_products
);
    import ycc555_pkg::*;

    logic signed [7:0] cb;
    logic signed [7:0] cr;

    // remove the 128 bias: flipping the top bit gives the signed value
    assign cb = {~i_chroma_blue[7], i_chroma_blue[6:0]};
    assign cr = {~i_chroma_red[7], i_chroma_red[6:0]};

    // four narrow Q16 products, registered by the caller
    assign o_products.red      = K_R  * cr;
    assign o_products.green_cb = K_GB * cb;
    assign o_products.green_cr = K_GR * cr;
    assign o_products.blue     = K_B  * cb;

endmodule

/* hdl/ycc555_lane.sv */
module ycc555_lane (
    input  logic [7:0]                     i_luma,
    input  logic [ycc555_pkg::DITH_W-1:0]  i_dither,
    input  ycc555_pkg::t_offsets           i_offsets,
    output logic [15:0]                    o_pixel
);
    import ycc555_pkg::*;

    logic signed [SUM_W-1:0] base;
    logic [4:0]              red5;
    logic [4:0]              green5;
    logic [4:0]              blue5;

    // luma + dither - 16, shared by the three channels
    assign base = $signed({4'b0, i_luma}) + $signed({{(SUM_W-DITH_W){1'b0}}, i_dither})
                  - LUMA_FLOOR;

    // add offset, clamp to 0..255, keep the top five bits
    function automatic logic [4:0] channel5(input logic signed [SUM_W-1:0] b,
                                            input logic signed [OFS_W-1:0] ofs);
        logic signed [SUM_W-1:0] v;
        logic [4:0]              r;
        v = b + {ofs[OFS_W-1], ofs};
        if (v < 0) begin
            r = 5'd0;
        end else if (v > CH_MAX) begin
            r = 5'd31;
        end else begin
            r = v[7:3];
        end
        return r;
    endfunction

    assign red5   = channel5(base, i_offsets.red);
    assign green5 = channel5(base, i_offsets.green);
    assign blue5  = channel5(base, i_offsets.blue);

    assign o_pixel = {1'b1, blue5, green5, red5};

endmodule

/* hdl/ycbcr_to_rgb555_dither_core.sv */
// Channel   Dir  Handshake      Payload
// i_blk     in   valid/ready    Cb, Cr and a 2x2 luma block (t_ycc_blk)
// o_pix     out  valid/ready    four RGB555 pixels (t_rgb_blk)
// i_cfg_*   in   write enable   dither mode, 2 bits
//
// One 2x2 block per cycle while o_pix is not stalled; an accepted block is registered
// in stage 1 and then in stage 2, whose valid register drives o_pix.valid.
// Stage 1 registers the four chroma products with the luma and dither per lane;
// stage 2 runs four pixel lanes and the merge into the output register.
// Reset (synchronous, active low) empties both stages and clears the dither mode.
// A stall on o_pix fills the stages; i_blk.ready drops only when both are full.
module ycbcr_to_rgb555_dither_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ycc555_in_if.sink   i_blk,
    ycc555_out_if.source o_pix,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);
    import ycc555_pkg::*;

    t_dither_mode      r_dither_mode;

    logic              r_v1;
    t_products         r_prod;
    logic [7:0]        r_luma   [LANES];
    logic [DITH_W-1:0] r_dither [LANES];

    logic              r_v2;
    t_rgb_blk          r_pix;

    logic              en1;
    logic              en2;
    t_products         n_prod;
    t_offsets          offsets;
    logic [15:0]       lane_pix [LANES];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dither_mode <= DITHER_OFF;
        end else if (i_cfg_we) begin
            r_dither_mode <= t_dither_mode'(i_cfg_wdata);
        end
    end

    // stage advance: a stage loads when it is empty or its contents move on
    assign en2         = !r_v2 || o_pix.ready;
    assign en1         = !r_v1 || en2;
    assign i_blk.ready = en1;

    ycc555_chroma_mul u_mul (
        .i_chroma_blue (i_blk.data.chroma_blue),
        .i_chroma_red  (i_blk.data.chroma_red),
        .o_products    (n_prod)
    );

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_blk.valid;
        end
    end

    // stage 1 payload: products, luma and dither per lane
    always_ff @(posedge i_clk) begin
        if (en1 && i_blk.valid) begin
            r_prod      <= n_prod;
            r_luma[0]   <= i_blk.data.luma_upper_left;
            r_luma[1]   <= i_blk.data.luma_upper_right;
            r_luma[2]   <= i_blk.data.luma_lower_left;
            r_luma[3]   <= i_blk.data.luma_lower_right;
            r_dither[0] <= dither_value(r_dither_mode, 2'd0);
            r_dither[1] <= dither_value(r_dither_mode, 2'd1);
            r_dither[2] <= dither_value(r_dither_mode, 2'd2);
            r_dither[3] <= dither_value(r_dither_mode, 2'd3);
        end
    end

    // floor by arithmetic shift of 16, green terms summed
    assign offsets.red   = {r_prod.red[PROD_W-1], r_prod.red[PROD_W-1:16]};
    assign offsets.blue  = {r_prod.blue[PROD_W-1], r_prod.blue[PROD_W-1:16]};
    assign offsets.green = {r_prod.green_cb[PROD_W-1], r_prod.green_cb[PROD_W-1:16]}
                         + {r_prod.green_cr[PROD_W-1], r_prod.green_cr[PROD_W-1:16]};

    // one lane per pixel of the block
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        ycc555_lane u_lane (
            .i_luma    (r_luma[g]),
            .i_dither  (r_dither[g]),
            .i_offsets (offsets),
            .o_pixel   (lane_pix[g])
        );
    end

    // stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    // merge lanes into the output register
    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_pix.pixel_upper_left  <= lane_pix[0];
            r_pix.pixel_upper_right <= lane_pix[1];
            r_pix.pixel_lower_left  <= lane_pix[2];
            r_pix.pixel_lower_right <= lane_pix[3];
        end
    end

    assign o_pix.valid = r_v2;
    assign o_pix.data  = r_pix;

    // every delivered pixel carries the top bit
    a_alpha_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.data.pixel_upper_left[15] && o_pix.data.pixel_upper_right[15]
                      && o_pix.data.pixel_lower_left[15] && o_pix.data.pixel_lower_right[15]))
        else $error("pixel without top bit");

    // an accepted transaction lands in stage 1
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_blk.valid && i_blk.ready) |=> r_v1)
        else $error("accepted transaction lost");

    // a stalled stage 1 keeps its transaction
    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !en2) |=> r_v1)
        else $error("stage 1 dropped under stall");

    // a full stage 1 moves into stage 2 when stage 2 frees up
    a_stage1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && en2) |=> r_v2)
        else $error("stage 1 transaction not forwarded");

    // with dither off, stage 1 holds no dither
    a_no_dither: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(en1 && i_blk.valid) && $past(r_dither_mode == DITHER_OFF))
        |-> (r_dither[0] == '0 && r_dither[1] == '0 && r_dither[2] == '0
             && r_dither[3] == '0))
        else $error("dither applied while off");

endmodule
